// ===== rtl/core/byte_budget_lru_cache_top_macros.svh =====
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_top_macros
// assertion macros for the byte budget lru cache
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_TOP_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_TOP_MACROS_SVH

// property that holds whenever reset is released
`define BBLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge
`define BBLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bblc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_pkg
// shared types and constants of the byte budget lru cache
// ----------------------------------------------------------------------------
package bblc_pkg;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyWords   = 8;
  localparam int unsigned KeyW       = 64 * KeyWords;
  localparam int unsigned RankW      = $clog2(MaxEntries);
  localparam int unsigned SlotW      = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam logic [39:0] MaxBytesRst    = 40'd1048576;
  localparam logic [11:0] HeaderBytesRst = 12'd64;

  localparam logic [0:0] RegMaxBytes    = 1'd0;
  localparam logic [0:0] RegHeaderBytes = 1'd1;

  localparam logic [2:0] StLookupHit  = 3'd0;
  localparam logic [2:0] StLookupMiss = 3'd1;
  localparam logic [2:0] StPresent    = 3'd2;
  localparam logic [2:0] StInserted   = 3'd3;
  localparam logic [2:0] StRejected   = 3'd4;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic             touch;    // make matched rank recent
    logic [RankW-1:0] ref_rank; // rank of the touched entry
    logic             evict;    // drop entry with the oldest rank
    logic [RankW-1:0] old_rank; // rank to evict
    logic             age_all;  // bump all valid ranks
    logic             write;    // write new entry
  } cell_cmd_t;
endpackage

// ===== rtl/core/byte_budget_lru_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_top
// fully associative lru cache of 16 cells with a byte budget
// ----------------------------------------------------------------------------
// channel | signals                                  | handshake
// command | start, mode_i, key_word*_i, counts       | start && !busy
// result  | hit_o, handle_out_o, status_o, bytes,... | done_o strobe, one cycle
// config  | psel/penable/pwrite/paddr/pwdata/prdata  | apb, pready always high
//
// a lookup or present insert goes SLook, SDone; a new insert goes SLook,
// SCost, SEvic, SFull, SWrit, SDone and a rejected one SLook, SCost,
// SEvic, SDone. the eviction loop in SEvic removes one entry per cycle.
// reset empties the cache at once. results cannot be stalled; a new
// command is taken once done_o has been shown.
module byte_budget_lru_cache_top import bblc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [63:0] key_word2_i,
  input  logic [63:0] key_word3_i,
  input  logic [63:0] key_word4_i,
  input  logic [63:0] key_word5_i,
  input  logic [63:0] key_word6_i,
  input  logic [63:0] key_word7_i,
  input  logic [31:0] value_handle_i,
  input  logic [31:0] node_count_i,
  input  logic [31:0] edge_count_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [31:0] handle_out_o,
  output logic [2:0]  status_o,
  output logic [39:0] bytes_in_use_o,
  output logic [4:0]  evicted_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLook = 3'd1;
  localparam logic [2:0] SCost = 3'd2;
  localparam logic [2:0] SEvic = 3'd3;
  localparam logic [2:0] SFull = 3'd4;
  localparam logic [2:0] SWrit = 3'd5;
  localparam logic [2:0] SDone = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [39:0]     max_bytes_q;
  logic [11:0]     header_q;
  logic            mode_q;
  logic [KeyW-1:0] key_q;
  logic [31:0]     vh_q, nodes_q, edges_q;
  logic [41:0]     cost_q, cost_d;
  logic [39:0]     used_q, used_d;
  logic [4:0]      evict_q, evict_d;
  logic            hit_q, hit_d;
  logic [31:0]     hout_q, hout_d;
  logic [2:0]      st_q, st_d;
  cell_cmd_t       cmd;
  logic            a_hit;
  logic [RankW-1:0] a_rank;
  logic [31:0]     a_handle;
  logic [CntW-1:0] a_count;
  logic [39:0]     a_old_cost;
  logic            cfg_wr;
  logic [42:0]     need;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state_q != SIdle);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesRst;
      header_q    <= HeaderBytesRst;
    end else if (cfg_wr) begin
      if (paddr == {RegMaxBytes, 3'b000}) max_bytes_q <= pwdata[39:0];
      if (paddr == {RegHeaderBytes, 3'b000}) header_q <= pwdata[11:0];
    end
  end

  always_comb begin
    unique case (paddr)
      {RegMaxBytes, 3'b000}:    prdata = {24'd0, max_bytes_q};
      {RegHeaderBytes, 3'b000}: prdata = {52'd0, header_q};
      default:                  prdata = '0;
    endcase
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      mode_q  <= mode_i;
      key_q   <= {key_word7_i, key_word6_i, key_word5_i, key_word4_i,
                  key_word3_i, key_word2_i, key_word1_i, key_word0_i};
      vh_q    <= value_handle_i;
      nodes_q <= node_count_i;
      edges_q <= edge_count_i;
    end
  end

  bblc_array u_array (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .key_i        (key_q),
    .handle_i     (vh_q),
    .cost_i       (cost_q[39:0]),
    .hit_o        (a_hit),
    .hit_rank_o   (a_rank),
    .hit_handle_o (a_handle),
    .count_o      (a_count),
    .old_cost_o   (a_old_cost)
  );

  assign need = {3'd0, used_q} + {1'b0, cost_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    cost_d  = cost_q;
    used_d  = used_q;
    evict_d = evict_q;
    hit_d   = hit_q;
    hout_d  = hout_q;
    st_d    = st_q;
    cmd     = '0;
    cmd.ref_rank = a_rank;
    cmd.old_rank = RankW'(a_count - 1'b1);
    unique case (state_q)
      SIdle: if (start) state_d = SLook;
      SLook: begin
        evict_d = '0;
        hout_d  = '0;
        hit_d   = a_hit;
        if (a_hit) begin
          cmd.touch = 1'b1;
          if (!mode_q) hout_d = a_handle;
          st_d    = mode_q ? StPresent : StLookupHit;
          state_d = SDone;
        end else if (!mode_q) begin
          st_d    = StLookupMiss;
          state_d = SDone;
        end else begin
          cost_d  = 42'(header_q) + ((42'(nodes_q) + 42'd1) << 2);
          state_d = SCost;
        end
      end
      SCost: begin
        cost_d  = cost_q + 42'(edges_q) * 42'd12;
        state_d = SEvic;
      end
      SEvic: begin
        if (need > 43'(max_bytes_q) && a_count != '0) begin
          cmd.evict = 1'b1;
          used_d  = (used_q >= a_old_cost) ? used_q - a_old_cost : '0;
          evict_d = evict_q + 1'b1;
        end else if (cost_q > 42'(max_bytes_q)) begin
          st_d    = StRejected;
          state_d = SDone;
        end else state_d = SFull;
      end
      SFull: begin
        if (a_count >= CntW'(MaxEntries)) begin
          cmd.evict = 1'b1;
          used_d  = (used_q >= a_old_cost) ? used_q - a_old_cost : '0;
          evict_d = evict_q + 1'b1;
        end
        state_d = SWrit;
      end
      SWrit: begin
        cmd.age_all = 1'b1;
        cmd.write   = 1'b1;
        used_d  = used_q + cost_q[39:0];
        st_d    = StInserted;
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= '0;
      evict_q <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      evict_q <= evict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    hit_q  <= hit_d;
    hout_q <= hout_d;
    st_q   <= st_d;
  end

  // result beat
  assign done_o          = (state_q == SDone);
  assign hit_o           = hit_q;
  assign handle_out_o    = hout_q;
  assign status_o        = st_q;
  assign bytes_in_use_o  = used_q;
  assign evicted_count_o = evict_q;

  `include "byte_budget_lru_cache_top_macros.svh"

  `BBLC_ASSERT_IMP(a_done_one, done_o, !$past(done_o), "done twice in a row")
  `BBLC_ASSERT_IMP(a_evict_cap, done_o, evicted_count_o <= 5'd16, "too many evictions")
  `BBLC_ASSERT(a_busy_after_start, start && !busy |=> busy, "start not taken")
endmodule

// ===== rtl/core/bblc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_cell
// one cache slot: key, handle, cost, valid and recency rank
// ----------------------------------------------------------------------------
module bblc_cell import bblc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic             sel_i,      // this slot takes the write
  input  logic [KeyW-1:0]  key_i,
  input  logic [31:0]      handle_i,
  input  logic [39:0]      cost_i,
  input  logic             free_in_i,  // a lower slot is free
  output logic             free_out_o,
  output logic             free_here_o,
  output logic             match_o,
  output logic             valid_o,
  output logic [RankW-1:0] rank_o,
  output logic [31:0]      handle_o,
  output logic [39:0]      cost_o
);
  logic [KeyW-1:0]  key_q;
  logic [31:0]      handle_q;
  logic [39:0]      cost_q;
  logic             valid_q, valid_d;
  logic [RankW-1:0] rank_q, rank_d;

  assign match_o     = valid_q && (key_q == key_i);
  assign valid_o     = valid_q;
  assign rank_o      = rank_q;
  assign handle_o    = handle_q;
  assign cost_o      = cost_q;
  // free slot chain: first free slot from index 0
  assign free_here_o = !valid_q && !free_in_i;
  assign free_out_o  = free_in_i || !valid_q;

  // rank and valid update
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.touch && valid_q) begin
      if (match_o) rank_d = '0;
      else if (rank_q < cmd_i.ref_rank) rank_d = rank_q + 1'b1;
    end
    if (cmd_i.evict && valid_q && rank_q == cmd_i.old_rank) begin
      valid_d = 1'b0;
      rank_d  = '0;
    end
    if (cmd_i.age_all && valid_q) rank_d = rank_q + 1'b1;
    if (cmd_i.write && sel_i) begin
      valid_d = 1'b1;
      rank_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && sel_i) begin
      key_q    <= key_i;
      handle_q <= handle_i;
      cost_q   <= cost_i;
    end
  end
endmodule

// ===== rtl/core/bblc_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblc_array
// row of cells with match, oldest entry and free slot reduction
// ----------------------------------------------------------------------------
module bblc_array import bblc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [31:0]      handle_i,
  input  logic [39:0]      cost_i,
  output logic             hit_o,
  output logic [RankW-1:0] hit_rank_o,
  output logic [31:0]      hit_handle_o,
  output logic [CntW-1:0]  count_o,
  output logic [39:0]      old_cost_o
);
  logic [MaxEntries-1:0]  match, valid, free_here;
  logic [MaxEntries:0]    free_chain;
  logic [RankW-1:0]       rank   [MaxEntries];
  logic [31:0]            handle [MaxEntries];
  logic [39:0]            cost   [MaxEntries];

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    bblc_cell u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .sel_i       (free_here[g]),
      .key_i, .handle_i, .cost_i,
      .free_in_i   (free_chain[g]),
      .free_out_o  (free_chain[g+1]),
      .free_here_o (free_here[g]),
      .match_o     (match[g]),
      .valid_o     (valid[g]),
      .rank_o      (rank[g]),
      .handle_o    (handle[g]),
      .cost_o      (cost[g])
    );
  end

  // or-reductions over one-hot match, plus valid count and oldest entry select
  always_comb begin
    hit_rank_o   = '0;
    hit_handle_o = '0;
    old_cost_o   = '0;
    count_o      = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (match[i]) begin
        hit_rank_o   = hit_rank_o | rank[i];
        hit_handle_o = hit_handle_o | handle[i];
      end
      count_o = count_o + CntW'(valid[i]);
    end
    // oldest valid rank is count-1
    for (int i = 0; i < MaxEntries; i++) begin
      if (valid[i] && (CntW'(rank[i]) == count_o - 1'b1)) old_cost_o = cost[i];
    end
  end

  assign hit_o = |match;
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the byte budget lru cache against a cycle-free model of its contents
// ----------------------------------------------------------------------------
// commands come from a short directed table, then from a pool of related keys
// so that hits, refreshes, budget evictions and full-cache evictions all
// happen. each done beat is compared with the oldest expected access result.
// the budget and header registers are rewritten over apb between phases.
module tb_top import bblc_pkg::*; ();

  localparam logic ModeLookup = 1'b0;
  localparam logic ModeInsert = 1'b1;
  localparam int   PoolSize   = 20;
  localparam int   IdleLimit  = 4000;
  localparam logic [39:0] BudgetMax = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic             mode;
    logic [7:0][63:0] key;
    logic [31:0]      handle;
    logic [31:0]      nodes;
    logic [31:0]      edges;
  } access_t;

  typedef struct {
    logic        hit;
    logic [31:0] handle;
    logic [2:0]  status;
    logic [39:0] bytes;
    logic [4:0]  evicted;
  } outcome_t;

  // directed row: pool key index, known outcome where one is given
  typedef struct {
    logic        mode;
    int          key_idx;
    logic [31:0] handle;
    logic [31:0] nodes;
    logic [31:0] edges;
    bit          known;
    outcome_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = 1'b0;
  logic [7:0][63:0] key_q = '0;
  logic [31:0] value_handle_i = '0;
  logic [31:0] node_count_i = '0;
  logic [31:0] edge_count_i = '0;
  logic        done_o, hit_o;
  logic [31:0] handle_out_o;
  logic [2:0]  status_o;
  logic [39:0] bytes_in_use_o;
  logic [4:0]  evicted_count_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  byte_budget_lru_cache_top i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i,
    .key_word0_i(key_q[0]), .key_word1_i(key_q[1]), .key_word2_i(key_q[2]),
    .key_word3_i(key_q[3]), .key_word4_i(key_q[4]), .key_word5_i(key_q[5]),
    .key_word6_i(key_q[6]), .key_word7_i(key_q[7]),
    .value_handle_i, .node_count_i, .edge_count_i,
    .done_o, .hit_o, .handle_out_o, .status_o, .bytes_in_use_o, .evicted_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cache contents as the testbench sees them
  logic [39:0]      budget = MaxBytesRst;
  logic [11:0]      overhead = HeaderBytesRst;
  logic [7:0][63:0] slot_key [MaxEntries];
  logic [31:0]      slot_handle [MaxEntries];
  logic [63:0]      slot_cost [MaxEntries];
  bit               slot_live [MaxEntries];
  int unsigned      slot_age [MaxEntries];
  logic [63:0]      bytes_used = '0;

  outcome_t         pending_q [$];
  logic [7:0][63:0] key_pool [PoolSize];
  int               errors = 0;
  int               n_items = 0, n_hits = 0, n_evict = 0, n_reject = 0;
  int               idle_cycles = 0;

  function automatic void touch_slot(int s);
    int unsigned r;
    r = slot_age[s];
    for (int i = 0; i < MaxEntries; i++)
      if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic bit drop_oldest();
    int v;
    v = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (slot_live[i] && (v < 0 || slot_age[i] > slot_age[v])) v = i;
    if (v < 0) return 0;
    slot_live[v] = 0;
    slot_age[v] = 0;
    bytes_used = (bytes_used >= slot_cost[v]) ? bytes_used - slot_cost[v] : '0;
    return 1;
  endfunction

  function automatic outcome_t predict_access(access_t a);
    outcome_t o;
    int       found, free_s, live;
    logic [63:0] cost;
    int unsigned ev;
    o = '{hit: 0, handle: '0, status: StLookupMiss, bytes: '0, evicted: '0};
    ev = 0;
    found = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == a.key) found = i;
    if (a.mode == ModeLookup) begin
      if (found >= 0) begin
        touch_slot(found);
        o.hit = 1;
        o.handle = slot_handle[found];
        o.status = StLookupHit;
      end
    end else if (found >= 0) begin
      touch_slot(found);
      o.hit = 1;
      o.status = StPresent;
    end else begin
      cost = 64'(overhead) + 64'd4 * (64'(a.nodes) + 64'd1) + 64'd12 * 64'(a.edges);
      while (bytes_used + cost > 64'(budget) && drop_oldest()) ev++;
      if (cost > 64'(budget)) begin
        o.status = StRejected;
      end else begin
        live = 0;
        for (int i = 0; i < MaxEntries; i++) live += slot_live[i];
        if (live >= MaxEntries && drop_oldest()) ev++;
        free_s = -1;
        for (int i = 0; i < MaxEntries; i++)
          if (free_s < 0 && !slot_live[i]) free_s = i;
        for (int i = 0; i < MaxEntries; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_key[free_s] = a.key;
        slot_handle[free_s] = a.handle;
        slot_cost[free_s] = cost;
        slot_live[free_s] = 1;
        slot_age[free_s] = 0;
        bytes_used = (bytes_used + cost) & 64'hFF_FFFF_FFFF;
        o.status = StInserted;
      end
    end
    o.bytes = bytes_used[39:0];
    o.evicted = (ev > 31) ? 5'd31 : 5'(ev);
    return o;
  endfunction

  // one command beat, then a random gap, possibly none, with start low
  task automatic issue_access(access_t a, bit known, outcome_t want);
    outcome_t p;
    int gap;
    start <= 1'b1;
    mode_i <= a.mode;
    key_q <= a.key;
    value_handle_i <= a.handle;
    node_count_i <= a.nodes;
    edge_count_i <= a.edges;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = predict_access(a);
    pending_q.push_back(known ? want : p);
    n_items++;
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for the cache to drain, then write one register over apb
  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0 || busy !== 1'b0);
    repeat (24) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegMaxBytes) budget = val[39:0];
    else overhead = val[11:0];
  endtask

  task automatic random_phase(int count, int big_pct);
    access_t a;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      a.mode = ($urandom_range(0, 9) < 4) ? ModeLookup : ModeInsert;
      a.key = key_pool[$urandom_range(0, PoolSize - 1)];
      // stray keys that never enter the pool
      if (k == 0) a.key[$urandom_range(0, 7)] = {$urandom, $urandom};
      a.handle = $urandom;
      if ($urandom_range(0, 99) < big_pct) begin
        a.nodes = $urandom;
        a.edges = $urandom;
      end else begin
        a.nodes = $urandom_range(0, 40);
        a.edges = $urandom_range(0, 40);
      end
      issue_access(a, 0, '{default: '0});
    end
  endtask

  // result beats against the oldest prediction
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d", $time, status_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (hit_o !== e.hit || handle_out_o !== e.handle || status_o !== e.status ||
            bytes_in_use_o !== e.bytes || evicted_count_o !== e.evicted) begin
          $display("%0t: expected hit %0d handle %h status %0d bytes %0d evicted %0d",
                   $time, e.hit, e.handle, e.status, e.bytes, e.evicted);
          $display("%0t:   actual hit %0d handle %h status %0d bytes %0d evicted %0d",
                   $time, hit_o, handle_out_o, status_o, bytes_in_use_o, evicted_count_o);
          errors++;
        end
        if (e.hit) n_hits++;
        if (e.status == StRejected) n_reject++;
        n_evict += e.evicted;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t     rows [$];
    access_t  a;
    outcome_t none;
    none = '{default: '0};
    for (int i = 0; i < MaxEntries; i++) begin
      slot_live[i] = 0;
      slot_age[i] = 0;
    end
    // related keys: some differ from the last one in a single word
    for (int i = 0; i < PoolSize; i++) begin
      for (int w = 0; w < 8; w++) key_pool[i][w] = {$urandom, $urandom};
      if (i > 0 && (i % 2)) begin
        key_pool[i] = key_pool[i - 1];
        key_pool[i][$urandom_range(0, 7)] ^= 64'(1) << $urandom_range(0, 63);
      end
    end
    key_pool[0] = '0;
    key_pool[2] = '1;

    rows = '{
      '{ModeLookup, 0, 32'h0, 0, 0, 1, '{0, 0, StLookupMiss, 0, 0}},
      '{ModeInsert, 0, 32'hFFFF_FFFF, 0, 0, 1, '{0, 0, StInserted, 68, 0}},
      '{ModeLookup, 0, 32'h0, 0, 0, 1, '{1, 32'hFFFF_FFFF, StLookupHit, 68, 0}},
      '{ModeInsert, 0, 32'h1234, 5, 5, 1, '{1, 0, StPresent, 68, 0}},
      '{ModeInsert, 2, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
        '{0, 0, StRejected, 0, 1}},
      '{ModeLookup, 0, 32'h0, 0, 0, 1, '{0, 0, StLookupMiss, 0, 0}},
      '{ModeInsert, 1, 32'hA5A5_5A5A, 100, 200, 0, none},
      '{ModeInsert, 3, 32'h0000_0001, 0, 32'hFFFF, 0, none},
      '{ModeLookup, 1, 32'h0, 0, 0, 0, none},
      '{ModeLookup, 4, 32'h0, 0, 0, 0, none}
    };
    // fill past the slot count so the oldest entry goes out
    for (int i = 0; i < 18; i++)
      rows.push_back('{ModeInsert, i + 2, 32'(i), 32'(i), 1, 0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      a.mode = rows[r].mode;
      a.key = key_pool[rows[r].key_idx];
      a.handle = rows[r].handle;
      a.nodes = rows[r].nodes;
      a.edges = rows[r].edges;
      issue_access(a, rows[r].known, rows[r].want);
    end

    random_phase(150, 3);
    // lowered budget leaves bytes above it until the next new insert
    write_reg(RegMaxBytes, 64'd700);
    write_reg(RegHeaderBytes, 64'd0);
    random_phase(150, 2);
    write_reg(RegMaxBytes, 64'(BudgetMax));
    write_reg(RegHeaderBytes, 64'd4095);
    random_phase(150, 30);
    write_reg(RegMaxBytes, 64'd0);
    random_phase(40, 5);
    write_reg(RegMaxBytes, 64'd3000);
    write_reg(RegHeaderBytes, 64'd64);
    random_phase(110, 2);

    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    repeat (30) @(posedge clk_i);
    $display("ran %0d commands: %0d hits, %0d entries evicted, %0d rejected inserts",
             n_items, n_hits, n_evict, n_reject);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
